// ===== design/mpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor PWM speed controller package
// Shared widths, menu codes, direction codes and command characters.
// ----------------------------------------------------------------------------
package mpsc_pkg;

   // Field widths.
   localparam int CharWidth   = 8;
   localparam int SampleWidth = 12;
   localparam int DutyWidth   = 7;
   localparam int ModeWidth   = 3;
   localparam int DirWidth    = 2;
   localparam int TickWidth   = 24;
   localparam int TppWidth    = 16;
   localparam int CsrWidth    = 16;

   // Menu states.
   localparam logic [ModeWidth-1:0] MODE_IDLE     = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_SOURCE   = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_DIR      = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_TERMINAL = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_POT      = 3'd4;

   // Rotation direction codes.
   localparam logic [DirWidth-1:0] DIR_CW        = 2'd0;
   localparam logic [DirWidth-1:0] DIR_CCW       = 2'd1;
   localparam logic [DirWidth-1:0] DIR_UNDECIDED = 2'd2;

   // Speed source codes.
   localparam logic [1:0] SRC_TERMINAL = 2'd0;
   localparam logic [1:0] SRC_POT      = 2'd1;
   localparam logic [1:0] SRC_NONE     = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TICKS_PER_PERCENT = 1'b0;
   localparam logic CSR_SAMPLE_DEADBAND   = 1'b1;

   // Command characters.
   localparam logic [CharWidth-1:0] CHAR_STAR = 8'h2A;
   localparam logic [CharWidth-1:0] CHAR_S    = 8'h73;
   localparam logic [CharWidth-1:0] CHAR_H    = 8'h68;
   localparam logic [CharWidth-1:0] CHAR_A    = 8'h61;
   localparam logic [CharWidth-1:0] CHAR_T    = 8'h74;
   localparam logic [CharWidth-1:0] CHAR_P    = 8'h70;
   localparam logic [CharWidth-1:0] CHAR_0    = 8'h30;
   localparam logic [CharWidth-1:0] CHAR_5    = 8'h35;
   localparam logic [CharWidth-1:0] CHAR_6    = 8'h36;
   localparam logic [CharWidth-1:0] CHAR_7    = 8'h37;
   localparam logic [CharWidth-1:0] CHAR_8    = 8'h38;
   localparam logic [CharWidth-1:0] CHAR_9    = 8'h39;

   // Numeric constants.
   localparam logic [DutyWidth-1:0]   FULL_PERCENT = 7'd100;
   localparam logic [SampleWidth-1:0] MID_SAMPLE   = 12'h800;
   localparam int                     MidShift     = 11;

   // Reset values of the configuration registers.
   localparam logic [TppWidth-1:0]    TPP_RESET      = 16'd800;
   localparam logic [SampleWidth-1:0] DEADBAND_RESET = 12'd20;

endpackage

// ===== design/mpsc_req_if.sv =====
// ----------------------------------------------------------------------------
// Motor PWM speed controller request channel
// Valid/ready channel that carries control steps and timer ticks.
// ----------------------------------------------------------------------------
interface mpsc_req_if import mpsc_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic                   char_valid;
   logic [CharWidth-1:0]   char_code;
   logic                   sample_valid;
   logic [SampleWidth-1:0] sample_value;

   modport source (
      output valid, action, char_valid, char_code, sample_valid, sample_value,
      input  ready
   );

   modport sink (
      input  valid, action, char_valid, char_code, sample_valid, sample_value,
      output ready
   );
endinterface

// ===== design/mpsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Motor PWM speed controller response channel
// Valid/ready channel that carries the controller state after each item.
// ----------------------------------------------------------------------------
interface mpsc_rsp_if import mpsc_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [ModeWidth-1:0]   menu_mode;
   logic [DirWidth-1:0]    rotation_dir;
   logic [DutyWidth-1:0]   duty_percent;
   logic [DutyWidth-1:0]   duty_target;
   logic                   motor_enable;
   logic                   drive_cw;
   logic                   drive_ccw;
   logic [SampleWidth-1:0] filtered_sample;

   modport source (
      output valid, menu_mode, rotation_dir, duty_percent, duty_target,
             motor_enable, drive_cw, drive_ccw, filtered_sample,
      input  ready
   );

   modport sink (
      input  valid, menu_mode, rotation_dir, duty_percent, duty_target,
             motor_enable, drive_cw, drive_ccw, filtered_sample,
      output ready
   );
endinterface

// ===== design/motor_pwm_speed_controller_core.sv =====
// ----------------------------------------------------------------------------
// Motor PWM speed controller core
// Menu machine, duty ramp, pot deadband filter and PWM interval timer for
// an H-bridge motor driver.
//
//   Channel | Direction | Handshake        | Contents
//   req     | in        | valid / ready    | control step or timer tick
//   rsp     | out       | valid / ready    | controller state after the item
//   csr     | in        | write enable     | ticks per percent, deadband
//
// One item is taken per cycle while rsp is not stalled. A transfer on req
// lands in an input register; the controller state, which is the response
// register, updates from it once the response slot is free.
// The single 7x16 interval multiplier sits in that update stage.
// Reset is synchronous and restores the power-up state and the register
// defaults. A stalled rsp holds the state; req keeps taking one more item
// into the input register while the response waits.
// ----------------------------------------------------------------------------
module motor_pwm_speed_controller_core import mpsc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   mpsc_req_if.sink            req,
   mpsc_rsp_if.source          rsp,
   input  logic                csr_write_en,
   input  logic                csr_index,
   input  logic [CsrWidth-1:0] csr_write_data
);

   // Configuration registers.
   logic [TppWidth-1:0]    tpp_ff;
   logic [SampleWidth-1:0] deadband_ff;

   // Input register.
   logic                   in_valid_ff;
   logic                   in_action_ff;
   logic                   in_char_valid_ff;
   logic [CharWidth-1:0]   in_char_code_ff;
   logic                   in_sample_valid_ff;
   logic [SampleWidth-1:0] in_sample_value_ff;

   // Controller state, which also forms the response register.
   logic                   rsp_valid_ff;
   logic [ModeWidth-1:0]   mode_ff,     mode_in;
   logic [DirWidth-1:0]    dir_ff,      dir_in;
   logic [1:0]             source_ff,   source_in;
   logic [CharWidth-1:0]   last_char_ff, last_char_in;
   logic [SampleWidth-1:0] pot_ff,      pot_in;
   logic [DutyWidth-1:0]   speed_now_ff,  speed_now_in;
   logic [DutyWidth-1:0]   speed_goal_ff, speed_goal_in;
   logic                   phase_ff,    phase_in;
   logic                   timer_on_ff, timer_on_in;
   logic [TickWidth-1:0]   tick_ff,     tick_in;
   logic                   enable_ff,   enable_in;
   logic [1:0]             bridge_ff,   bridge_in;

   // Datapath helpers.
   logic                   advance;
   logic [SampleWidth-1:0] sample_diff;
   logic [SampleWidth-1:0] pot_dist;
   logic [18:0]            pot_scaled;
   logic [DutyWidth-1:0]   interval;
   logic [DutyWidth-1:0]   mult_op;
   logic [TickWidth-1:0]   reload;

   // Pipeline control: the state updates when the response slot is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff      <= TPP_RESET;
         deadband_ff <= DEADBAND_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TICKS_PER_PERCENT: tpp_ff      <= csr_write_data;
            CSR_SAMPLE_DEADBAND:   deadband_ff <= csr_write_data[SampleWidth-1:0];
            default:               tpp_ff      <= tpp_ff;
         endcase
      end
   end

   // Input register capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_action_ff       <= req.action;
         in_char_valid_ff   <= req.char_valid;
         in_char_code_ff    <= req.char_code;
         in_sample_valid_ff <= req.sample_valid;
         in_sample_value_ff <= req.sample_value;
      end
   end

   // PWM interval selection on timer expiry.
   always_comb begin
      if (speed_now_ff == '0) begin
         interval = FULL_PERCENT;
      end else if (speed_now_ff >= FULL_PERCENT) begin
         interval = FULL_PERCENT;
      end else if (!phase_ff) begin
         interval = speed_now_ff;
      end else begin
         interval = FULL_PERCENT - speed_now_ff;
      end
   end

   // Shared interval multiplier: a control step only ever loads a full period.
   assign mult_op = in_action_ff ? interval : FULL_PERCENT;
   assign reload  = TickWidth'({{TppWidth{1'b0}}, mult_op} * {{DutyWidth{1'b0}}, tpp_ff});

   // Pot deadband and speed scaling from the filtered value.
   always_comb begin
      last_char_in = in_char_valid_ff ? in_char_code_ff : last_char_ff;
      sample_diff  = (in_sample_value_ff >= pot_ff) ? in_sample_value_ff - pot_ff
                                                    : pot_ff - in_sample_value_ff;
      pot_in       = (in_sample_valid_ff && sample_diff >= deadband_ff)
                     ? in_sample_value_ff : pot_ff;
      pot_dist     = (pot_in < MID_SAMPLE) ? MID_SAMPLE - pot_in : pot_in - MID_SAMPLE;
      pot_scaled   = {7'd0, pot_dist} * 19'(FULL_PERCENT);
   end

   // Next state for control steps and timer ticks.
   always_comb begin
      mode_in       = mode_ff;
      dir_in        = dir_ff;
      source_in     = source_ff;
      speed_now_in  = speed_now_ff;
      speed_goal_in = speed_goal_ff;
      phase_in      = phase_ff;
      timer_on_in   = timer_on_ff;
      tick_in       = tick_ff;
      enable_in     = enable_ff;
      bridge_in     = bridge_ff;

      if (in_action_ff) begin
         // Timer tick: count down, then set the phase (low at zero duty, high at full duty, else toggled) and reload.
         if (timer_on_ff) begin
            if (tick_ff <= TickWidth'(1)) begin
               if (speed_now_ff == '0) begin
                  phase_in = 1'b0;
               end else if (speed_now_ff >= FULL_PERCENT) begin
                  phase_in = 1'b1;
               end else begin
                  phase_in = !phase_ff;
               end
               bridge_in = (dir_ff == DIR_CW) ? {1'b0, phase_in} : {phase_in, 1'b0};
               tick_in   = reload;
            end else begin
               tick_in = tick_ff - TickWidth'(1);
            end
         end
      end else begin
         // Control step: ramp the duty one percent toward the target.
         if (speed_now_ff < speed_goal_ff) begin
            speed_now_in = speed_now_ff + DutyWidth'(1);
         end else if (speed_now_ff > speed_goal_ff) begin
            speed_now_in = speed_now_ff - DutyWidth'(1);
         end

         // Menu machine.
         unique case (mode_ff)
            MODE_IDLE: begin
               if (last_char_in == CHAR_STAR) begin
                  mode_in = MODE_SOURCE;
               end
               dir_in        = DIR_UNDECIDED;
               source_in     = SRC_NONE;
               speed_goal_in = '0;
               speed_now_in  = '0;
            end
            MODE_SOURCE: begin
               if (last_char_in == CHAR_T) begin
                  source_in = SRC_TERMINAL;
               end else if (last_char_in == CHAR_P) begin
                  source_in = SRC_POT;
               end
               if (source_in == SRC_TERMINAL) begin
                  mode_in = MODE_DIR;
               end else if (source_in == SRC_POT) begin
                  mode_in     = MODE_POT;
                  enable_in   = 1'b1;
                  phase_in    = 1'b0;
                  bridge_in   = 2'b00;
                  tick_in     = reload;
                  timer_on_in = 1'b1;
               end
            end
            MODE_DIR: begin
               if (last_char_in == CHAR_H) begin
                  dir_in = DIR_CW;
               end else if (last_char_in == CHAR_A) begin
                  dir_in = DIR_CCW;
               end
               if (dir_in != DIR_UNDECIDED) begin
                  mode_in     = MODE_TERMINAL;
                  enable_in   = 1'b1;
                  phase_in    = 1'b0;
                  bridge_in   = 2'b00;
                  tick_in     = reload;
                  timer_on_in = 1'b1;
               end
            end
            MODE_TERMINAL: begin
               case (last_char_in)
                  CHAR_5:  speed_goal_in = 7'd50;
                  CHAR_6:  speed_goal_in = 7'd60;
                  CHAR_7:  speed_goal_in = 7'd70;
                  CHAR_8:  speed_goal_in = 7'd80;
                  CHAR_9:  speed_goal_in = 7'd90;
                  CHAR_0:  speed_goal_in = FULL_PERCENT;
                  default: speed_goal_in = speed_goal_ff;
               endcase
               if (last_char_in == CHAR_S) begin
                  mode_in     = MODE_IDLE;
                  enable_in   = 1'b0;
                  phase_in    = 1'b0;
                  bridge_in   = 2'b00;
                  timer_on_in = 1'b0;
               end
            end
            MODE_POT: begin
               if (last_char_in == CHAR_S) begin
                  mode_in     = MODE_IDLE;
                  enable_in   = 1'b0;
                  phase_in    = 1'b0;
                  bridge_in   = 2'b00;
                  timer_on_in = 1'b0;
               end else begin
                  dir_in        = (pot_in < MID_SAMPLE) ? DIR_CW : DIR_CCW;
                  speed_goal_in = pot_scaled[MidShift+DutyWidth-1:MidShift];
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // State and response register update.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_IDLE;
         dir_ff        <= DIR_UNDECIDED;
         source_ff     <= SRC_NONE;
         last_char_ff  <= '0;
         pot_ff        <= '0;
         speed_now_ff  <= '0;
         speed_goal_ff <= '0;
         phase_ff      <= 1'b0;
         timer_on_ff   <= 1'b0;
         tick_ff       <= '0;
         enable_ff     <= 1'b0;
         bridge_ff     <= 2'b00;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff       <= mode_in;
            dir_ff        <= dir_in;
            source_ff     <= source_in;
            last_char_ff  <= in_action_ff ? last_char_ff : last_char_in;
            pot_ff        <= in_action_ff ? pot_ff : pot_in;
            speed_now_ff  <= speed_now_in;
            speed_goal_ff <= speed_goal_in;
            phase_ff      <= phase_in;
            timer_on_ff   <= timer_on_in;
            tick_ff       <= tick_in;
            enable_ff     <= enable_in;
            bridge_ff     <= bridge_in;
         end
      end
   end

   // Response outputs come straight from the state.
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.menu_mode       = mode_ff;
   assign rsp.rotation_dir    = dir_ff;
   assign rsp.duty_percent    = speed_now_ff;
   assign rsp.duty_target     = speed_goal_ff;
   assign rsp.motor_enable    = enable_ff;
   assign rsp.drive_cw        = bridge_ff[0];
   assign rsp.drive_ccw       = bridge_ff[1];
   assign rsp.filtered_sample = pot_ff;

   // The bridge enable and the interval timer switch on and off together.
   assert property (@(posedge clock) disable iff (reset) enable_ff == timer_on_ff)
      else $error("bridge enable and PWM timer disagree");

   // Both bridge inputs are never driven high at once.
   assert property (@(posedge clock) disable iff (reset) bridge_ff != 2'b11)
      else $error("both bridge inputs high");

   // A response that waits keeps the controller state unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(mode_ff) && $stable(tick_ff)
                                      && $stable(speed_now_ff))
      else $error("state changed under a stalled response");

   // Outside idle entry the duty moves by at most one percent per item.
   assert property (@(posedge clock) disable iff (reset)
      advance && mode_ff != MODE_IDLE |=>
         (speed_now_ff - $past(speed_now_ff) == 7'd1) ||
         ($past(speed_now_ff) - speed_now_ff == 7'd1) ||
         (speed_now_ff == $past(speed_now_ff)))
      else $error("duty ramp stepped by more than one percent");

endmodule

// ===== tb/tb_motor_pwm_speed_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor PWM speed controller core testbench
// Drives control steps and timer ticks through the request channel and
// checks every response against a cycle-free predictor of the menu machine,
// duty ramp, pot deadband and PWM timer. A directed table comes first, then
// randomized menu sessions under several register settings, with random
// idle gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_motor_pwm_speed_controller_core;
   import mpsc_pkg::*;

   localparam logic ACT_STEP = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // Cycles to let pass after the last result before touching the registers.
   localparam int SETTLE_CYCLES = 6;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 183;

   typedef struct packed {
      logic                   action;
      logic                   char_valid;
      logic [CharWidth-1:0]   char_code;
      logic                   sample_valid;
      logic [SampleWidth-1:0] sample_value;
   } stim_item_type;

   typedef struct packed {
      logic [ModeWidth-1:0]   menu_mode;
      logic [DirWidth-1:0]    rotation_dir;
      logic [DutyWidth-1:0]   duty_percent;
      logic [DutyWidth-1:0]   duty_target;
      logic                   motor_enable;
      logic                   drive_cw;
      logic                   drive_ccw;
      logic [SampleWidth-1:0] filtered_sample;
   } rsp_fields_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic                   action;
      logic                   char_valid;
      logic [CharWidth-1:0]   char_code;
      logic                   sample_valid;
      logic [SampleWidth-1:0] sample_value;
      logic [7:0]             reps;
      logic                   typed;
      rsp_fields_type         want;
      logic                   csr_idx;
      logic [CsrWidth-1:0]    csr_data;
   } plan_row_type;

   typedef struct {
      logic [ModeWidth-1:0]   mode;
      logic [DirWidth-1:0]    dir;
      logic [1:0]             source;
      logic [CharWidth-1:0]   last_char;
      logic [SampleWidth-1:0] pot;
      logic [DutyWidth-1:0]   duty_now;
      logic [DutyWidth-1:0]   duty_goal;
      logic                   phase;
      logic                   timer_on;
      logic [TickWidth-1:0]   ticks_left;
      logic                   enable;
      logic [1:0]             bridge;
   } ctrl_shadow_type;

   // States whose every field can be read off directly.
   localparam rsp_fields_type NO_WANT  = '0;
   localparam rsp_fields_type AT_RESET =
      '{MODE_IDLE, DIR_UNDECIDED, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 12'd0};
   localparam rsp_fields_type IDLE_TOP =
      '{MODE_IDLE, DIR_UNDECIDED, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 12'd4095};
   localparam rsp_fields_type IDLE_4075 =
      '{MODE_IDLE, DIR_UNDECIDED, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 12'd4075};
   localparam rsp_fields_type SOURCE_4075 =
      '{MODE_SOURCE, DIR_UNDECIDED, 7'd0, 7'd0, 1'b0, 1'b0, 1'b0, 12'd4075};
   localparam rsp_fields_type POT_ON =
      '{MODE_POT, DIR_UNDECIDED, 7'd0, 7'd0, 1'b1, 1'b0, 1'b0, 12'd0};

   // Directed table: kind, action, char valid/code, sample valid/value, repeats,
   // typed flag, typed state, register index and data.
   localparam plan_row_type DIRECTED [27] = '{
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd1, 1'b1, AT_RESET, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b1, 12'd4095, 8'd1, 1'b1, IDLE_TOP, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b1, 12'd4076, 8'd1, 1'b1, IDLE_TOP, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b1, 12'd4075, 8'd1, 1'b1, IDLE_4075, 1'b0, 16'd0},
      '{ROW_CSR, ACT_STEP, 1'b0, 8'h00, 1'b0, 12'd0, 8'd0, 1'b0, NO_WANT,
        CSR_TICKS_PER_PERCENT, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_STAR, 1'b0, 12'd0, 8'd1, 1'b1, SOURCE_4075, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_P, 1'b1, 12'd0, 8'd1, 1'b1, POT_ON, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b1, 8'hFF, 1'b1, 12'd4095, 8'd1, 1'b1, POT_ON, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b0, 12'd0, 8'd4, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd4, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b1, 12'd4095, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd3, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_S, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b0, 12'd0, 8'd1, 1'b1, IDLE_TOP, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd1, 1'b1, IDLE_TOP, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_STAR, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_T, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_H, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_0, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b0, 8'h00, 1'b0, 12'd0, 8'd100, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd3, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_A, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_5, 1'b0, 12'd0, 8'd3, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_TICK, 1'b0, 8'h00, 1'b0, 12'd0, 8'd3, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, CHAR_S, 1'b0, 12'd0, 8'd1, 1'b0, NO_WANT, 1'b0, 16'd0},
      '{ROW_ITEM, ACT_STEP, 1'b1, 8'hFF, 1'b0, 12'd0, 8'd1, 1'b1, IDLE_TOP, 1'b0, 16'd0}
   };

   // Register settings of the random phases, extremes included.
   localparam logic [TppWidth-1:0] PHASE_TPP [NUM_PHASES] =
      '{16'd1, 16'd65535, 16'd3, 16'd0, 16'd2, 16'd800, 16'd1, 16'd5};
   localparam logic [SampleWidth-1:0] PHASE_DEADBAND [NUM_PHASES] =
      '{12'd0, 12'd4095, 12'd20, 12'd7, 12'd4095, 12'd20, 12'd100, 12'd0};

   localparam logic [CharWidth-1:0] CMD_POOL [12] = '{CHAR_STAR, CHAR_S, CHAR_H, CHAR_A,
      CHAR_T, CHAR_P, CHAR_0, CHAR_5, CHAR_6, CHAR_7, CHAR_8, CHAR_9};
   localparam logic [CharWidth-1:0] DIGIT_POOL [6] =
      '{CHAR_0, CHAR_5, CHAR_6, CHAR_7, CHAR_8, CHAR_9};

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_en;
   logic                csr_index;
   logic [CsrWidth-1:0] csr_write_data;

   mpsc_req_if req_ch ();
   mpsc_rsp_if rsp_ch ();

   motor_pwm_speed_controller_core dut (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   ctrl_shadow_type        ctl;
   logic [TppWidth-1:0]    cfg_tpp;
   logic [SampleWidth-1:0] cfg_deadband;
   rsp_fields_type         expected_states [$];
   stim_item_type          plan_q [$];
   bit                     quiet;
   int                     stall_left;
   int                     fail_count;
   int                     items_sent;
   int                     results_seen;
   int                     expiries;
   int                     full_duty_expiries;

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bridge start and stop, as the menu machine issues them.
   function automatic void start_bridge();
      ctl.enable     = 1'b1;
      ctl.phase      = 1'b0;
      ctl.bridge     = 2'b00;
      ctl.ticks_left = TickWidth'(int'(FULL_PERCENT) * int'(cfg_tpp));
      ctl.timer_on   = 1'b1;
   endfunction

   function automatic void stop_bridge();
      ctl.enable   = 1'b0;
      ctl.phase    = 1'b0;
      ctl.bridge   = 2'b00;
      ctl.timer_on = 1'b0;
   endfunction

   // Advances the shadow controller by one item and returns the state after it.
   function automatic rsp_fields_type predict_controller(stim_item_type it);
      int unsigned    span;
      int             interval;
      int             pv;
      rsp_fields_type r;
      if (it.action == ACT_TICK) begin
         if (ctl.timer_on) begin
            if (ctl.ticks_left <= 1) begin
               expiries++;
               if (ctl.duty_now == 0) begin
                  ctl.phase = 1'b0;
                  interval  = int'(FULL_PERCENT);
               end else if (ctl.duty_now >= FULL_PERCENT) begin
                  ctl.phase = 1'b1;
                  interval  = int'(FULL_PERCENT);
                  full_duty_expiries++;
               end else if (ctl.phase == 1'b0) begin
                  ctl.phase = 1'b1;
                  interval  = int'(ctl.duty_now);
               end else begin
                  ctl.phase = 1'b0;
                  interval  = int'(FULL_PERCENT) - int'(ctl.duty_now);
               end
               ctl.bridge = (ctl.dir == DIR_CW) ? {1'b0, ctl.phase} : {ctl.phase, 1'b0};
               ctl.ticks_left = TickWidth'(interval * int'(cfg_tpp));
            end else begin
               ctl.ticks_left--;
            end
         end
      end else begin
         if (it.char_valid) ctl.last_char = it.char_code;

         // Deadband on the absolute distance from the held pot value.
         if (it.sample_valid) begin
            span = (it.sample_value >= ctl.pot) ? it.sample_value - ctl.pot
                                                : ctl.pot - it.sample_value;
            if (span >= cfg_deadband) ctl.pot = it.sample_value;
         end

         // One percent of ramp per control step, ahead of the menu.
         if (ctl.duty_now < ctl.duty_goal) ctl.duty_now++;
         else if (ctl.duty_now > ctl.duty_goal) ctl.duty_now--;

         case (ctl.mode)
            MODE_IDLE: begin
               if (ctl.last_char == CHAR_STAR) ctl.mode = MODE_SOURCE;
               ctl.dir       = DIR_UNDECIDED;
               ctl.source    = SRC_NONE;
               ctl.duty_goal = '0;
               ctl.duty_now  = '0;
            end
            MODE_SOURCE: begin
               if (ctl.last_char == CHAR_T) ctl.source = SRC_TERMINAL;
               else if (ctl.last_char == CHAR_P) ctl.source = SRC_POT;
               if (ctl.source == SRC_TERMINAL) begin
                  ctl.mode = MODE_DIR;
               end else if (ctl.source == SRC_POT) begin
                  ctl.mode = MODE_POT;
                  start_bridge();
               end
            end
            MODE_DIR: begin
               if (ctl.last_char == CHAR_H) ctl.dir = DIR_CW;
               else if (ctl.last_char == CHAR_A) ctl.dir = DIR_CCW;
               if (ctl.dir != DIR_UNDECIDED) begin
                  ctl.mode = MODE_TERMINAL;
                  start_bridge();
               end
            end
            MODE_TERMINAL: begin
               case (ctl.last_char)
                  CHAR_5: ctl.duty_goal = 7'd50;
                  CHAR_6: ctl.duty_goal = 7'd60;
                  CHAR_7: ctl.duty_goal = 7'd70;
                  CHAR_8: ctl.duty_goal = 7'd80;
                  CHAR_9: ctl.duty_goal = 7'd90;
                  CHAR_0: ctl.duty_goal = FULL_PERCENT;
                  default: ;
               endcase
               if (ctl.last_char == CHAR_S) begin
                  stop_bridge();
                  ctl.mode = MODE_IDLE;
               end
            end
            MODE_POT: begin
               pv = int'(ctl.pot);
               if (ctl.last_char == CHAR_S) begin
                  stop_bridge();
                  ctl.mode = MODE_IDLE;
               end else if (ctl.pot < MID_SAMPLE) begin
                  ctl.dir       = DIR_CW;
                  ctl.duty_goal = DutyWidth'((int'(FULL_PERCENT) * (int'(MID_SAMPLE) - pv))
                                             / int'(MID_SAMPLE));
               end else begin
                  ctl.dir       = DIR_CCW;
                  ctl.duty_goal = DutyWidth'((int'(FULL_PERCENT) * (pv - int'(MID_SAMPLE)))
                                             / int'(MID_SAMPLE));
               end
            end
            default: ctl.mode = MODE_IDLE;
         endcase
      end

      r.menu_mode       = ctl.mode;
      r.rotation_dir    = ctl.dir;
      r.duty_percent    = ctl.duty_now;
      r.duty_target     = ctl.duty_goal;
      r.motor_enable    = ctl.enable;
      r.drive_cw        = ctl.bridge[0];
      r.drive_ccw       = ctl.bridge[1];
      r.filtered_sample = ctl.pot;
      return r;
   endfunction

   function automatic stim_item_type step_item(logic cv, logic [CharWidth-1:0] code, logic sv,
                                               logic [SampleWidth-1:0] sval);
      stim_item_type it;
      it.action       = ACT_STEP;
      it.char_valid   = cv;
      it.char_code    = code;
      it.sample_valid = sv;
      it.sample_value = sval;
      return it;
   endfunction

   // A tick carries random content in the fields that it ignores.
   function automatic stim_item_type tick_item();
      stim_item_type it;
      it              = stim_item_type'($urandom);
      it.action       = ACT_TICK;
      return it;
   endfunction

   // Half the time a menu command, otherwise any byte.
   function automatic logic [CharWidth-1:0] pick_char();
      if ($urandom_range(0, 1) == 0) return CMD_POOL[$urandom_range(0, 11)];
      return CharWidth'($urandom_range(0, 255));
   endfunction

   function automatic stim_item_type idle_step();
      return step_item(1'b0, CharWidth'($urandom), 1'(($urandom_range(0, 3) == 0)),
                       SampleWidth'($urandom));
   endfunction

   function automatic stim_item_type noise_step();
      return step_item(1'b1, pick_char(), 1'($urandom), SampleWidth'($urandom));
   endfunction

   // One menu session: enter, pick a source, run the speed, stop; or a broken session of random items.
   task automatic plan_session();
      int path;
      int pick;
      int n;
      int guess;
      repeat ($urandom_range(0, 3)) plan_q.push_back(noise_step());
      plan_q.push_back(step_item(1'b1, ($urandom_range(0, 9) == 0) ? pick_char() : CHAR_STAR,
                                 1'($urandom), SampleWidth'($urandom)));
      path = $urandom_range(0, 9);
      if (path < 5) begin
         // Terminal speed, with a sticky source character first.
         plan_q.push_back(step_item(1'b1, CHAR_T, 1'($urandom), SampleWidth'($urandom)));
         repeat ($urandom_range(0, 2)) plan_q.push_back(idle_step());
         plan_q.push_back(step_item(1'b1, ($urandom_range(0, 1) == 0) ? CHAR_H : CHAR_A,
                                    1'($urandom), SampleWidth'($urandom)));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 140) : $urandom_range(10, 50);
         repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
               plan_q.push_back(step_item(1'b1, DIGIT_POOL[$urandom_range(0, 5)],
                                          1'($urandom), SampleWidth'($urandom)));
            else if (pick < 7) plan_q.push_back(idle_step());
            else if (pick < 9) repeat ($urandom_range(1, 30)) plan_q.push_back(tick_item());
            else plan_q.push_back(noise_step());
         end
      end else if (path < 9) begin
         // Potentiometer speed: jumps and small wiggles around the deadband.
         guess = $urandom_range(0, 4095);
         plan_q.push_back(step_item(1'b1, CHAR_P, 1'b1, SampleWidth'(guess)));
         repeat ($urandom_range(10, 50)) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               if ($urandom_range(0, 3) == 0) guess = $urandom_range(0, 4095);
               else guess = guess + $urandom_range(0, 60) - 30;
               if (guess < 0) guess = 0;
               if (guess > 4095) guess = 4095;
               plan_q.push_back(step_item(1'b0, CharWidth'($urandom), 1'b1,
                                          SampleWidth'(guess)));
            end else if (pick < 8) begin
               repeat ($urandom_range(1, 30)) plan_q.push_back(tick_item());
            end else begin
               plan_q.push_back(noise_step());
            end
         end
      end else begin
         // Broken session: whatever comes.
         repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) == 0) plan_q.push_back(noise_step());
            else plan_q.push_back(tick_item());
         end
      end
      if (path < 9) begin
         plan_q.push_back(step_item(1'b1, CHAR_S, 1'($urandom), SampleWidth'($urandom)));
         plan_q.push_back(idle_step());
      end
   endtask

   // One request transfer after a random gap; the expectation is queued on accept.
   task automatic drive_item(stim_item_type it, bit typed, rsp_fields_type want);
      int             gap;
      rsp_fields_type exp_state;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= it.action;
      req_ch.char_valid   <= it.char_valid;
      req_ch.char_code    <= it.char_code;
      req_ch.sample_valid <= it.sample_valid;
      req_ch.sample_value <= it.sample_value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      exp_state = predict_controller(it);
      expected_states.push_back(typed ? want : exp_state);
      items_sent++;
      if (items_sent % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
   endtask

   // Waits until every result is in and the pipeline is empty.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_states.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [CsrWidth-1:0] data);
      csr_index      <= idx;
      csr_write_data <= data;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TICKS_PER_PERCENT) cfg_tpp = data;
      else cfg_deadband = data[SampleWidth-1:0];
   endtask

   task automatic check_state(rsp_fields_type want, rsp_fields_type got);
      if (got.menu_mode !== want.menu_mode) begin
         $error("menu_mode: expected %0d, actual %0d", want.menu_mode, got.menu_mode);
         fail_count++;
      end
      if (got.rotation_dir !== want.rotation_dir) begin
         $error("rotation_dir: expected %0d, actual %0d", want.rotation_dir, got.rotation_dir);
         fail_count++;
      end
      if (got.duty_percent !== want.duty_percent) begin
         $error("duty_percent: expected %0d, actual %0d", want.duty_percent, got.duty_percent);
         fail_count++;
      end
      if (got.duty_target !== want.duty_target) begin
         $error("duty_target: expected %0d, actual %0d", want.duty_target, got.duty_target);
         fail_count++;
      end
      if (got.motor_enable !== want.motor_enable) begin
         $error("motor_enable: expected %0d, actual %0d", want.motor_enable, got.motor_enable);
         fail_count++;
      end
      if (got.drive_cw !== want.drive_cw) begin
         $error("drive_cw: expected %0d, actual %0d", want.drive_cw, got.drive_cw);
         fail_count++;
      end
      if (got.drive_ccw !== want.drive_ccw) begin
         $error("drive_ccw: expected %0d, actual %0d", want.drive_ccw, got.drive_ccw);
         fail_count++;
      end
      if (got.filtered_sample !== want.filtered_sample) begin
         $error("filtered_sample: expected %0d, actual %0d", want.filtered_sample,
                got.filtered_sample);
         fail_count++;
      end
   endtask

   // Response side: check each transfer, then stall for a random number of cycles.
   always @(posedge clock) begin
      rsp_fields_type got;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.menu_mode       = rsp_ch.menu_mode;
            got.rotation_dir    = rsp_ch.rotation_dir;
            got.duty_percent    = rsp_ch.duty_percent;
            got.duty_target     = rsp_ch.duty_target;
            got.motor_enable    = rsp_ch.motor_enable;
            got.drive_cw        = rsp_ch.drive_cw;
            got.drive_ccw       = rsp_ch.drive_ccw;
            got.filtered_sample = rsp_ch.filtered_sample;
            if (expected_states.size() == 0) begin
               $error("response transfer with no expected state waiting");
               fail_count++;
            end else begin
               check_state(expected_states.pop_front(), got);
            end
            results_seen++;
            stall_left = quiet ? 0 : $urandom_range(0, 10);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   // Main sequence: reset, directed table, random phases, final report.
   initial begin
      plan_row_type  row;
      stim_item_type it;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_STEP;
      req_ch.char_valid   = 1'b0;
      req_ch.char_code    = '0;
      req_ch.sample_valid = 1'b0;
      req_ch.sample_value = '0;
      rsp_ch.ready        = 1'b0;
      csr_write_en        = 1'b0;
      csr_index           = CSR_TICKS_PER_PERCENT;
      csr_write_data      = '0;
      reset               = 1'b1;
      quiet               = 1'b0;
      stall_left          = 0;
      fail_count          = 0;
      items_sent          = 0;
      results_seen        = 0;
      expiries            = 0;
      full_duty_expiries  = 0;
      cfg_tpp             = TPP_RESET;
      cfg_deadband        = DEADBAND_RESET;
      ctl.mode            = MODE_IDLE;
      ctl.dir             = DIR_UNDECIDED;
      ctl.source          = SRC_NONE;
      ctl.last_char       = '0;
      ctl.pot             = '0;
      ctl.duty_now        = '0;
      ctl.duty_goal       = '0;
      ctl.phase           = 1'b0;
      ctl.timer_on        = 1'b0;
      ctl.ticks_left      = '0;
      ctl.enable          = 1'b0;
      ctl.bridge          = 2'b00;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         row = DIRECTED[r];
         if (row.kind == ROW_CSR) begin
            settle();
            write_reg(row.csr_idx, row.csr_data);
         end else begin
            it = step_item(row.char_valid, row.char_code, row.sample_valid, row.sample_value);
            it.action = row.action;
            repeat (row.reps) drive_item(it, row.typed, row.want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         write_reg(CSR_TICKS_PER_PERCENT, PHASE_TPP[p]);
         write_reg(CSR_SAMPLE_DEADBAND, {{(CsrWidth-SampleWidth){1'b0}}, PHASE_DEADBAND[p]});
         plan_q.delete();
         while (plan_q.size() < PHASE_ITEMS) plan_session();
         while (plan_q.size() > PHASE_ITEMS) void'(plan_q.pop_back());
         foreach (plan_q[i]) drive_item(plan_q[i], 1'b0, NO_WANT);
      end

      settle();
      $display("Run covered %0d request transfers over %0d register settings, %0d responses.",
               items_sent, NUM_PHASES + 1, results_seen);
      $display("PWM intervals expired %0d times, %0d of them at full duty.",
               expiries, full_duty_expiries);
      if (fail_count == 0) begin
         $display("[motor_pwm_speed_controller_core] OK");
      end else begin
         $display("[motor_pwm_speed_controller_core] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2ms;
      $display("[motor_pwm_speed_controller_core] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
design/mpsc_pkg.sv
design/mpsc_req_if.sv
design/mpsc_rsp_if.sv
design/motor_pwm_speed_controller_core.sv
tb/tb_motor_pwm_speed_controller_core.sv
